### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that b holds in the same cycle as a.
`define ALWP_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("alwp assertion failed");

// Check that b holds in the cycle after a.
`define ALWP_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("alwp assertion failed");

`endif

### rtl/alwp_pkg.sv
package alwp_pkg;

  localparam int NUM_JOBS    = 64;
  localparam int NUM_WORKERS = 16;

  localparam int JobW       = $clog2(NUM_JOBS);
  localparam int WorkerW    = $clog2(NUM_WORKERS);
  localparam int LoadW      = 7;
  localparam int LoadMax    = 127;
  localparam int JobFieldW  = 6;
  localparam int MaskFieldW = 16;
  localparam int WorkerFieldW = 4;

  typedef logic [NUM_WORKERS-1:0] worker_mask_t;
  typedef logic [LoadW-1:0]       load_t;

  typedef struct packed {
    logic [JobFieldW-1:0]  job_index;
    logic [MaskFieldW-1:0] free_mask;
  } alwp_in_t;

  typedef struct packed {
    logic [WorkerFieldW-1:0] worker;
    logic                    newly_assigned;
    logic                    no_free_worker;
  } alwp_out_t;

endpackage

### rtl/alwp_select.sv
module alwp_select
  import alwp_pkg::*;
(
  input  worker_mask_t row_i,
  input  worker_mask_t free_i,
  input  load_t        load_i [NUM_WORKERS],
  output alwp_out_t    result_o
);

  localparam int Slots = 2 ** WorkerW;

  worker_mask_t       hit;
  logic [WorkerW-1:0] hit_idx;
  logic               node_vld [1:2*Slots-1];
  load_t              node_ld  [1:2*Slots-1];
  logic [WorkerW-1:0] node_idx [1:2*Slots-1];
  logic               take_left;

  assign hit = row_i & free_i;

  always_comb begin
    hit_idx = '0;
    for (int w = NUM_WORKERS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_idx = WorkerW'(w);
      end
    end
  end

  always_comb begin
    take_left = 1'b0;
    for (int s = 0; s < Slots; s++) begin
      if (s < NUM_WORKERS) begin
        node_vld[Slots+s] = free_i[s];
        node_ld[Slots+s]  = load_i[s];
      end else begin
        node_vld[Slots+s] = 1'b0;
        node_ld[Slots+s]  = '0;
      end
      node_idx[Slots+s] = WorkerW'(s);
    end
    for (int n = Slots - 1; n >= 1; n--) begin
      take_left = node_vld[2*n] &&
                  (!node_vld[2*n+1] || (node_ld[2*n] <= node_ld[2*n+1]));
      node_vld[n] = node_vld[2*n] || node_vld[2*n+1];
      node_ld[n]  = take_left ? node_ld[2*n]  : node_ld[2*n+1];
      node_idx[n] = take_left ? node_idx[2*n] : node_idx[2*n+1];
    end
  end

  always_comb begin
    result_o = '0;
    if (free_i == '0) begin
      result_o.no_free_worker = 1'b1;
    end else if (hit != '0) begin
      result_o.worker = WorkerFieldW'(hit_idx);
    end else begin
      result_o.worker         = WorkerFieldW'(node_idx[1]);
      result_o.newly_assigned = 1'b1;
    end
  end

endmodule

### rtl/affinity_least_loaded_worker_picker_unit.sv
// Worker picker with job affinity. Each request carries a job index and a mask
// of free workers; the result returns the lowest free worker already paired
// with the job, or else pairs the job with the least loaded free worker (ties
// to the lowest number) and bumps that worker's load, which saturates at 127.
// An empty mask flags no_free_worker and leaves the state alone. One request
// is in flight at a time: the transfer reads the job's pairing row from the
// synchronous memory into a register, and the select state then selects,
// writes back and loads the result register once the output is free; the
// unit then returns to idle and takes the next request.
// A result held by a stalled output keeps the next request waiting in the
// select cycle. Pairing rows and load counts are clear right after reset with
// no clearing pass: each row carries a valid bit.
module affinity_least_loaded_worker_picker_unit
  import alwp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  alwp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output alwp_out_t out_data_o
);

  typedef enum logic {
    StIdle,
    StCalc
  } state_e;

  state_e              state_q;
  logic [JobW-1:0]     job_q;
  worker_mask_t        free_q;
  worker_mask_t        rd_q;
  logic [NUM_JOBS-1:0] row_vld_q;
  load_t               load_q [NUM_WORKERS];
  logic                out_valid_q;
  alwp_out_t           out_data_q;

  worker_mask_t        rows_mem [NUM_JOBS];

  logic                in_xfer;
  logic                out_free;
  logic                commit;
  logic                wr_en;
  worker_mask_t        row_eff;
  worker_mask_t        wr_row;
  logic [WorkerW-1:0]  sel_idx;
  alwp_out_t           sel;

  assign in_ready_o  = (state_q == StIdle);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign commit      = (state_q == StCalc) && out_free;
  assign row_eff     = row_vld_q[job_q] ? rd_q : '0;
  assign sel_idx     = sel.worker[WorkerW-1:0];
  assign wr_en       = commit && sel.newly_assigned;
  assign wr_row      = row_eff | (worker_mask_t'(1) << sel_idx);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  alwp_select u_select (
    .row_i    (row_eff),
    .free_i   (free_q),
    .load_i   (load_q),
    .result_o (sel)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= rows_mem[in_data_i.job_index[JobW-1:0]];
    end
    if (wr_en) begin
      rows_mem[job_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      job_q       <= '0;
      free_q      <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      for (int w = 0; w < NUM_WORKERS; w++) begin
        load_q[w] <= '0;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_xfer) begin
            job_q   <= in_data_i.job_index[JobW-1:0];
            free_q  <= in_data_i.free_mask[NUM_WORKERS-1:0];
            state_q <= StCalc;
          end
        end
        StCalc: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            out_data_q  <= sel;
            state_q     <= StIdle;
            if (sel.newly_assigned) begin
              row_vld_q[job_q] <= 1'b1;
              if (load_q[sel_idx] != load_t'(LoadMax)) begin
                load_q[sel_idx] <= load_q[sel_idx] + load_t'(1);
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

### rtl/alwp_checker.sv
`include "assert_macros.svh"

module alwp_checker
  import alwp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input alwp_out_t out_data_o
);

  logic in_xfer;
  logic out_stall;
  logic err_shown;
  logic err_clean;
  logic new_shown;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign err_shown = out_valid_o && out_data_o.no_free_worker;
  assign err_clean = (out_data_o.worker == '0) && !out_data_o.newly_assigned;
  assign new_shown = out_valid_o && out_data_o.newly_assigned;

  `ALWP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))
  `ALWP_ASSERT_SAME(a_err_fields, clk_i, rst_ni, err_shown, err_clean)
  `ALWP_ASSERT_SAME(a_new_no_err, clk_i, rst_ni, new_shown, !out_data_o.no_free_worker)
  `ALWP_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer, !in_ready_o)

endmodule

bind affinity_least_loaded_worker_picker_unit alwp_checker u_alwp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
